### hdl/msc_pkg.sv
package msc_pkg;

    // largest target held by the count table
    localparam int MAX_TARGET = 16383;

    // table geometry
    localparam int TABLE_DEPTH = MAX_TARGET + 1;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // field widths
    localparam int TARGET_W = 14;
    localparam int COUNT_W  = 3;

    // root step and its square, one bit of headroom past the target range
    localparam int STEP_W = 8;
    localparam int SQ_W   = ADDR_W + 1;

    // saturated count, also the starting value of the running minimum
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [STEP_W-1:0]  t_step;
    typedef logic [SQ_W-1:0]    t_sq;

endpackage

### hdl/min_square_sum_count.sv
// timing: targets 0 and 1 answer in the cycle after the request; for a target n >= 2
//   the block fills entries 2..n in turn, each with a scan and a finish step, paced by
//   the single read port of the count table (one table read per cycle in the scan)
// throughput: one request at a time, busy until the one-cycle result strobe; no stall
// reset: synchronous active low, returns to idle with no result pending; table
//   contents are not cleared, entries 0 and 1 are supplied by logic
module min_square_sum_count (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [msc_pkg::TARGET_W-1:0] i_target_value,
    output logic                         o_valid,
    output logic [msc_pkg::COUNT_W-1:0]  o_square_count
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam msc_pkg::t_addr ADDR_ZERO = '0;
    localparam msc_pkg::t_addr ADDR_ONE  = msc_pkg::t_addr'(1);
    localparam msc_pkg::t_addr ADDR_TWO  = msc_pkg::t_addr'(2);

    logic [1:0]      r_state, n_state;
    msc_pkg::t_addr  r_target, n_target;
    msc_pkg::t_addr  r_outer, n_outer;
    msc_pkg::t_step  r_step, n_step;
    msc_pkg::t_sq    r_sq, n_sq;
    msc_pkg::t_count r_min, n_min;
    logic            r_rd_pend, n_rd_pend;
    logic            r_rd_sub, n_rd_sub;
    msc_pkg::t_count r_sub_val, n_sub_val;
    logic            r_valid, n_valid;
    msc_pkg::t_count r_count, n_count;

    // count table, one write and one registered read per cycle
    msc_pkg::t_count r_table [0:msc_pkg::TABLE_DEPTH-1];
    msc_pkg::t_count r_rd_data;

    logic            rd_en;
    msc_pkg::t_addr  rd_addr;
    logic            wr_en;
    msc_pkg::t_count wr_data;

    msc_pkg::t_addr  req_target;
    msc_pkg::t_sq    outer_ext;
    logic            sq_fits;
    msc_pkg::t_sq    diff;
    msc_pkg::t_count rd_val;
    msc_pkg::t_count min_fold;
    msc_pkg::t_count entry_val;

    // request target, clipped to the table range
    always_comb begin
        if (32'(i_target_value) > msc_pkg::MAX_TARGET) begin
            req_target = msc_pkg::t_addr'(msc_pkg::MAX_TARGET);
        end else begin
            req_target = msc_pkg::t_addr'(i_target_value);
        end
    end

    // shared datapath: square compare, read address and running minimum
    always_comb begin
        outer_ext = msc_pkg::t_sq'(r_outer);
        sq_fits   = (r_sq <= outer_ext);
        diff      = outer_ext - r_sq;
        rd_addr   = diff[msc_pkg::ADDR_W-1:0];
        rd_val    = r_rd_sub ? r_sub_val : r_rd_data;
        if (r_rd_pend && (rd_val < r_min)) begin
            min_fold = rd_val;
        end else begin
            min_fold = r_min;
        end
        if (min_fold >= msc_pkg::COUNT_MAX) begin
            entry_val = msc_pkg::COUNT_MAX;
        end else begin
            entry_val = min_fold + msc_pkg::t_count'(1);
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_target  = r_target;
        n_outer   = r_outer;
        n_step    = r_step;
        n_sq      = r_sq;
        n_min     = min_fold;
        n_rd_pend = 1'b0;
        n_rd_sub  = 1'b0;
        n_sub_val = '0;
        n_valid   = 1'b0;
        n_count   = r_count;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_data   = entry_val;
        case (r_state)
            ST_IDLE: begin
                n_min = msc_pkg::COUNT_MAX;
                if (start) begin
                    if (req_target < ADDR_TWO) begin
                        // targets zero and one answer directly
                        n_valid = 1'b1;
                        n_count = msc_pkg::t_count'(req_target);
                    end else begin
                        n_state  = ST_SCAN;
                        n_target = req_target;
                        n_outer  = ADDR_TWO;
                        n_step   = msc_pkg::t_step'(1);
                        n_sq     = msc_pkg::t_sq'(1);
                    end
                end
            end
            ST_SCAN: begin
                if (sq_fits) begin
                    // read entry i - j*j, entries 0 and 1 come from logic
                    rd_en     = 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_sub  = (rd_addr == ADDR_ZERO) || (rd_addr == ADDR_ONE);
                    n_sub_val = msc_pkg::t_count'(rd_addr == ADDR_ONE);
                    n_sq      = r_sq + msc_pkg::t_sq'({r_step, 1'b1});
                    n_step    = r_step + msc_pkg::t_step'(1);
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // last read folded in, store the entry
                wr_en = 1'b1;
                n_min = msc_pkg::COUNT_MAX;
                if (r_outer == r_target) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    n_count = entry_val;
                end else begin
                    n_state = ST_SCAN;
                    n_outer = r_outer + msc_pkg::t_addr'(1);
                    n_step  = msc_pkg::t_step'(1);
                    n_sq    = msc_pkg::t_sq'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[r_outer] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_pend <= 1'b0;
            r_valid   <= 1'b0;
            r_min     <= msc_pkg::COUNT_MAX;
            r_outer   <= '0;
            r_step    <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            r_valid   <= n_valid;
            r_min     <= n_min;
            r_outer   <= n_outer;
            r_step    <= n_step;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_target  <= n_target;
        r_sq      <= n_sq;
        r_rd_sub  <= n_rd_sub;
        r_sub_val <= n_sub_val;
        r_count   <= n_count;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_square_count = r_count;

    // an accepted request either starts work or answers in the next cycle
    a_start_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("request accepted but nothing followed");

    // results never exceed four squares
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_square_count <= msc_pkg::t_count'(4)))
        else $error("square count out of range");

    // the block is idle whenever a result is shown
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // the entry being filled never passes the target
    a_outer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> (r_outer <= r_target))
        else $error("table fill ran past target");

    // every finished entry had at least one table read folded in
    a_finish_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> (r_min != msc_pkg::COUNT_MAX))
        else $error("entry stored without a read");

endmodule

### test/tb_min_square_sum_count.sv
`timescale 1ns / 100ps

module tb_min_square_sum_count;

    typedef logic [msc_pkg::TARGET_W-1:0] t_target;

    // each pending answer keeps its target for the mismatch report
    typedef struct {
        t_target         target;
        msc_pkg::t_count count;
    } t_answer;

    localparam int CLK_HALF     = 4;
    localparam int RANDOM_REQS  = 80;
    localparam int DRAIN_CYCLES = 50;
    localparam longint LIMIT_CYCLES = 16_000_000;

    // minimum square count predictor and expected answer store
    class square_count_board;
        msc_pkg::t_count counts [msc_pkg::TABLE_DEPTH];
        t_answer         pending_answers [$];
        int              errors;

        function new();
            errors = 0;
        endfunction

        // rebuild the count table up to the target, as the block does per request
        function msc_pkg::t_count min_squares(int unsigned tgt);
            int unsigned     n;
            int unsigned     k;
            int unsigned     r;
            msc_pkg::t_count best;
            n = (tgt > msc_pkg::MAX_TARGET) ? msc_pkg::MAX_TARGET : tgt;
            counts[0] = '0;
            counts[1] = 3'd1;
            for (k = 2; k <= n; k++) begin
                best = msc_pkg::COUNT_MAX;
                for (r = 1; r * r <= k; r++) begin
                    if (counts[k - r * r] < best)
                        best = counts[k - r * r];
                end
                // saturate instead of wrapping
                counts[k] = (best == msc_pkg::COUNT_MAX) ? msc_pkg::COUNT_MAX
                                                         : msc_pkg::t_count'(best + 3'd1);
            end
            return counts[n];
        endfunction

        function void note_request(t_target tgt);
            t_answer a;
            a.target = tgt;
            a.count  = min_squares(tgt);
            pending_answers.push_back(a);
        endfunction

        function void check_result(msc_pkg::t_count actual);
            t_answer a;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected square_count %0d with no request pending",
                         $time, actual);
                errors++;
                return;
            end
            a = pending_answers.pop_front();
            if (actual !== a.count) begin
                $display("%0t: square_count mismatch for target %0d: expected %0d, got %0d",
                         $time, a.target, a.count, actual);
                errors++;
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    t_target         i_target_value;
    logic            o_valid;
    msc_pkg::t_count o_square_count;

    square_count_board board;
    longint            cycle_count;
    int                burst_left;

    min_square_sum_count dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_target_value (i_target_value),
        .o_valid        (o_valid),
        .o_square_count (o_square_count)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: run limit reached with %0d answers pending",
                     $time, board.pending());
            $display("** min_square_sum_count: FAILED **");
            $finish;
        end
    end

    // result monitor, results cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result(o_square_count);
    end

    // idle length before a request: mostly short, a few long, some bursts with none
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            burst_left = $urandom_range(4, 12);
            return 0;
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly small targets, since run time grows faster than the target itself
    function automatic t_target pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return t_target'($urandom_range(0, 1));
        if (r < 85) return t_target'($urandom_range(2, 127));
        if (r < 97) return t_target'($urandom_range(128, 511));
        return t_target'($urandom_range(512, 1023));
    endfunction

    // issue one request; start stays high across back-to-back requests
    task automatic send_target(input t_target tgt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_target_value <= tgt;
        do @(posedge i_clk); while (busy);
        board.note_request(tgt);
    endtask

    int unsigned directed_list [] = '{
        0, 1, 2, 3, 4, 7, 12, 13, 15, 16, 25, 28, 0, 1, 127, 255, 256, 1023, 16383, 5
    };

    initial begin
        board          = new();
        burst_left     = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_target_value = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, squares, four-square cases, all-ones target
        foreach (directed_list[k])
            send_target(t_target'(directed_list[k]));

        // random requests
        for (int n = 0; n < RANDOM_REQS; n++)
            send_target(pick_target());
        start <= 1'b0;

        // drain
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("** min_square_sum_count: PASSED **");
        end else begin
            $display("** min_square_sum_count: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/msc_pkg.sv
hdl/min_square_sum_count.sv
test/tb_min_square_sum_count.sv
